// File: rtl/lapedge_pkg.sv
// Shared constants, register map and line buffer control type for the
// Laplacian edge threshold block. No dependencies.
package lapedge_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int THR_W      = 10;
  localparam int MIN_SIZE   = 3;
  localparam int LUMA_W     = 22;
  localparam int LUMA_SHIFT = 14;
  localparam int LUMA_B     = 1868;
  localparam int LUMA_G     = 9617;
  localparam int LUMA_R     = 4899;
  localparam int LUMA_ROUND = 8192;
  localparam int ADDR_W     = 4;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;

  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 12'd480;
  localparam logic [THR_W-1:0]    RST_THR    = 10'd23;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic [COL_W-1:0] rd_addr_right;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
  } lb_ctrl_t;

endpackage

// File: rtl/lapedge_line_buf.sv
// Two line buffers of gray pixels (previous row and the row before it).
// Depends on lapedge_pkg.
module lapedge_line_buf (
  input  logic                          clk,
  input  lapedge_pkg::lb_ctrl_t         ctrl,
  input  logic [lapedge_pkg::PIX_W-1:0] newer_wdata,
  input  logic [lapedge_pkg::PIX_W-1:0] older_wdata,
  output logic [lapedge_pkg::PIX_W-1:0] newer_rd,
  output logic [lapedge_pkg::PIX_W-1:0] newer_rd_right,
  output logic [lapedge_pkg::PIX_W-1:0] older_rd
);

  logic [lapedge_pkg::PIX_W-1:0] newer_mem [lapedge_pkg::MAX_WIDTH];
  logic [lapedge_pkg::PIX_W-1:0] older_mem [lapedge_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      newer_mem[ctrl.wr_addr] <= newer_wdata;
      older_mem[ctrl.wr_addr] <= older_wdata;
    end
    if (ctrl.rd_en) begin
      newer_rd       <= newer_mem[ctrl.rd_addr];
      newer_rd_right <= newer_mem[ctrl.rd_addr_right];
      older_rd       <= older_mem[ctrl.rd_addr];
    end
  end

endmodule

// File: rtl/laplacian_edge_threshold.sv
// Top level of the Laplacian edge threshold block: luma, position tracking,
// Laplacian and threshold, APB registers. Depends on lapedge_pkg, lapedge_line_buf.
//
// Takes one BGR pixel per clock (unless the output stalls) in raster order and
// returns one edge word per pixel from the second row on, describing the pixel
// one row above (the last row of a frame is never output). A pixel passes the
// line buffer read and compute stage registers, then the output register. The
// single read-modify-write of the line buffer memories per pixel, with
// write-to-read forwarding between neighbors, sets that rate. Border pixels
// give 0. Registers: frame_width at 0x0, frame_height at 0x4, edge_threshold at
// 0x8; write them only while the stream is idle.
module laplacian_edge_threshold (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,  // blue_in, green_in, red_in
  input  logic                           s_tuser,  // start_of_frame
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // edge_value
  output logic                           m_tlast,  // last_emitted
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lapedge_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int COL_W = lapedge_pkg::COL_W;
  localparam int ROW_W = lapedge_pkg::ROW_W;
  localparam int PIX_W = lapedge_pkg::PIX_W;
  localparam int WW    = lapedge_pkg::WIDTH_W;
  localparam int HW    = lapedge_pkg::HEIGHT_W;
  localparam int TW    = lapedge_pkg::THR_W;
  localparam int LW    = lapedge_pkg::LUMA_W;

  // configuration
  logic [WW-1:0] frame_width;
  logic [HW-1:0] frame_height;
  logic [TW-1:0] edge_threshold;
  logic          cfg_wr;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= lapedge_pkg::RST_WIDTH;
      frame_height   <= lapedge_pkg::RST_HEIGHT;
      edge_threshold <= lapedge_pkg::RST_THR;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lapedge_pkg::REG_FRAME_WIDTH:  frame_width    <= pwdata[WW-1:0];
        lapedge_pkg::REG_FRAME_HEIGHT: frame_height   <= pwdata[HW-1:0];
        lapedge_pkg::REG_THRESHOLD:    edge_threshold <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lapedge_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      lapedge_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      lapedge_pkg::REG_THRESHOLD:    prdata = 32'(edge_threshold);
      default:                       prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (frame_width < WW'(lapedge_pkg::MIN_SIZE)) begin
      eff_w = WW'(lapedge_pkg::MIN_SIZE);
    end else if (frame_width > WW'(lapedge_pkg::MAX_WIDTH)) begin
      eff_w = WW'(lapedge_pkg::MAX_WIDTH);
    end else begin
      eff_w = frame_width;
    end
    if (frame_height < HW'(lapedge_pkg::MIN_SIZE)) begin
      eff_h = HW'(lapedge_pkg::MIN_SIZE);
    end else begin
      eff_h = frame_height;
    end
  end

  // input stage: position and luma
  logic             accept;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count_next;
  logic [WW-1:0]    c_pos;
  logic [ROW_W:0]   r_pos;
  logic [ROW_W:0]   r_plus;
  logic [COL_W-1:0] cur_c;
  logic [ROW_W-1:0] cur_r;
  logic [WW-1:0]    c_plus;
  logic             right_ok;
  logic [LW-1:0]    luma_sum;
  logic [PIX_W-1:0] gray;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    c_pos = s_tuser ? '0 : WW'(column_count);
    r_pos = s_tuser ? '0 : (ROW_W+1)'(row_count);
    if (c_pos >= eff_w) begin
      c_pos = '0;
      r_pos = r_pos + 1'b1;
    end
    if (r_pos >= (ROW_W+1)'(eff_h)) begin
      r_pos = '0;
    end
    cur_c    = c_pos[COL_W-1:0];
    cur_r    = r_pos[ROW_W-1:0];
    c_plus   = WW'(cur_c) + 1'b1;
    right_ok = c_plus < eff_w;
    r_plus   = (ROW_W+1)'(cur_r) + 1'b1;
    if (right_ok) begin
      column_count_next = c_plus[COL_W-1:0];
      row_count_next    = cur_r;
    end else begin
      column_count_next = '0;
      row_count_next    = (r_plus >= (ROW_W+1)'(eff_h)) ? '0 : r_plus[ROW_W-1:0];
    end
  end

  assign luma_sum = LW'(lapedge_pkg::LUMA_B) * LW'(s_tdata[7:0])
                  + LW'(lapedge_pkg::LUMA_G) * LW'(s_tdata[15:8])
                  + LW'(lapedge_pkg::LUMA_R) * LW'(s_tdata[23:16])
                  + LW'(lapedge_pkg::LUMA_ROUND);
  assign gray = luma_sum[lapedge_pkg::LUMA_SHIFT +: PIX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // compute stage: line buffer data arrives, read-modify-write
  logic             s1_valid;
  logic             s1_adv;
  logic [COL_W-1:0] s1_c;
  logic [PIX_W-1:0] s1_gray;
  logic             s1_emit;
  logic             s1_inner;
  logic             s1_last;
  logic             fwd_c;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_newer;
  logic [PIX_W-1:0] fwd_older;
  logic [PIX_W-1:0] window_left;
  logic [PIX_W-1:0] centre;
  logic [PIX_W-1:0] right;
  logic [PIX_W-1:0] up;
  logic [PIX_W-1:0] newer_rd;
  logic [PIX_W-1:0] newer_rd_right;
  logic [PIX_W-1:0] older_rd;
  logic signed [11:0] lap;
  logic [10:0]        mag;
  logic [PIX_W-1:0]   edge_val;
  lapedge_pkg::lb_ctrl_t lb_ctrl;

  assign s1_adv   = s1_valid && (!s1_emit || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_c      <= cur_c;
      s1_gray   <= gray;
      s1_emit   <= cur_r != '0;
      s1_inner  <= (cur_r >= ROW_W'(2)) && (cur_c != '0) && right_ok;
      s1_last   <= (cur_r == ROW_W'(eff_h - 1'b1)) && !right_ok;
      fwd_c     <= s1_adv && (s1_c == cur_c);
      fwd_r     <= s1_adv && (s1_c == c_plus[COL_W-1:0]);
      fwd_newer <= s1_gray;
      fwd_older <= centre;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left <= '0;
    end else if (s1_adv) begin
      window_left <= centre;
    end
  end

  assign centre = fwd_c ? fwd_newer : newer_rd;
  assign right  = fwd_r ? fwd_newer : newer_rd_right;
  assign up     = fwd_c ? fwd_older : older_rd;

  always_comb begin
    lap = {2'b00, centre, 2'b00} - 12'(window_left) - 12'(right) - 12'(up) - 12'(s1_gray);
    mag = lap[11] ? 11'(-lap) : lap[10:0];
    edge_val = (s1_inner && (mag > 11'(edge_threshold))) ? '1 : '0;
  end

  assign lb_ctrl.rd_en         = accept;
  assign lb_ctrl.rd_addr       = cur_c;
  assign lb_ctrl.rd_addr_right = c_plus[COL_W-1:0];
  assign lb_ctrl.wr_en         = s1_adv;
  assign lb_ctrl.wr_addr       = s1_c;

  lapedge_line_buf u_line_buf (
    .clk            (clk),
    .ctrl           (lb_ctrl),
    .newer_wdata    (s1_gray),
    .older_wdata    (centre),
    .newer_rd       (newer_rd),
    .newer_rd_right (newer_rd_right),
    .older_rd       (older_rd)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      m_tdata <= edge_val;
      m_tlast <= s1_last;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !s_tready)
    else $error("input accepted while compute stage stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emit && !s1_adv |-> m_tvalid && !m_tready)
    else $error("compute stage stalled without output backpressure");

  a_last_is_border: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == '0)
    else $error("last word of frame is not a border zero");

endmodule

// File: test/tb.sv
// Testbench for laplacian_edge_threshold: drives random BGR pixel streams and
// APB register writes, and predicts every edge word with a scoreboard class.
// Depends on lapedge_pkg and the laplacian_edge_threshold RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [lapedge_pkg::PIX_W-1:0] value;
    logic                          last;
  } edge_word_t;

  class lap_edge_predictor;
    logic [lapedge_pkg::WIDTH_W-1:0]  width_reg;
    logic [lapedge_pkg::HEIGHT_W-1:0] height_reg;
    logic [lapedge_pkg::THR_W-1:0]    thr_reg;
    logic [lapedge_pkg::PIX_W-1:0]    older_row [lapedge_pkg::MAX_WIDTH];
    logic [lapedge_pkg::PIX_W-1:0]    newer_row [lapedge_pkg::MAX_WIDTH];
    logic [lapedge_pkg::PIX_W-1:0]    win_left;
    logic [lapedge_pkg::PIX_W-1:0]    win_centre;
    int                               col;
    int                               row;
    edge_word_t                       edge_words [$];
    int                               failures;

    function new();
      width_reg  = lapedge_pkg::RST_WIDTH;
      height_reg = lapedge_pkg::RST_HEIGHT;
      thr_reg    = lapedge_pkg::RST_THR;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      win_left   = '0;
      win_centre = '0;
      col        = 0;
      row        = 0;
      failures   = 0;
    endfunction

    function int eff_width();
      int w;
      w = width_reg;
      if (w < lapedge_pkg::MIN_SIZE) w = lapedge_pkg::MIN_SIZE;
      if (w > lapedge_pkg::MAX_WIDTH) w = lapedge_pkg::MAX_WIDTH;
      return w;
    endfunction

    function int eff_height();
      int h;
      h = height_reg;
      if (h < lapedge_pkg::MIN_SIZE) h = lapedge_pkg::MIN_SIZE;
      if (h > (1 << lapedge_pkg::HEIGHT_W) - 1) h = (1 << lapedge_pkg::HEIGHT_W) - 1;
      return h;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] val);
      case (idx)
        lapedge_pkg::REG_FRAME_WIDTH: width_reg = val[lapedge_pkg::WIDTH_W-1:0];
        lapedge_pkg::REG_FRAME_HEIGHT: height_reg = val[lapedge_pkg::HEIGHT_W-1:0];
        lapedge_pkg::REG_THRESHOLD: thr_reg = val[lapedge_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(logic [1:0] idx);
      case (idx)
        lapedge_pkg::REG_FRAME_WIDTH: return 32'(width_reg);
        lapedge_pkg::REG_FRAME_HEIGHT: return 32'(height_reg);
        lapedge_pkg::REG_THRESHOLD: return 32'(thr_reg);
        default: return 32'd0;
      endcase
    endfunction

    function int pending();
      return edge_words.size();
    endfunction

    function void predict_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic sof);
      int w, h, c, rw, luma, lap, mag;
      logic [lapedge_pkg::PIX_W-1:0] gray, up, right;
      edge_word_t e;
      w = eff_width();
      h = eff_height();
      luma = (lapedge_pkg::LUMA_B * int'(b) + lapedge_pkg::LUMA_G * int'(g)
              + lapedge_pkg::LUMA_R * int'(r) + lapedge_pkg::LUMA_ROUND)
             >> lapedge_pkg::LUMA_SHIFT;
      gray = luma[lapedge_pkg::PIX_W-1:0];
      if (sof) begin
        col = 0;
        row = 0;
      end
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      c  = col;
      rw = row;
      win_left   = win_centre;
      win_centre = newer_row[c];
      up         = older_row[c];
      right      = (c + 1 < w) ? newer_row[c+1] : '0;
      if (rw >= 1) begin
        e.value = '0;
        if (rw >= 2 && c >= 1 && c + 1 < w) begin
          lap = 4 * int'(win_centre) - int'(win_left) - int'(right) - int'(up) - int'(gray);
          mag = (lap < 0) ? -lap : lap;
          e.value = (mag > int'(thr_reg)) ? 8'd255 : 8'd0;
        end
        e.last = (rw == h - 1 && c == w - 1);
        edge_words.push_back(e);
      end
      older_row[c] = newer_row[c];
      newer_row[c] = gray;
      col = c + 1;
      if (col >= w) begin
        col = 0;
        row = rw + 1;
        if (row >= h) row = 0;
      end
    endfunction

    function void check_word(logic [7:0] value, logic last);
      edge_word_t e;
      if (edge_words.size() == 0) begin
        $error("unexpected word: edge_value %0d last_emitted %0d", value, last);
        failures++;
        return;
      end
      e = edge_words.pop_front();
      if (value !== e.value) begin
        $error("edge_value: expected %0d, actual %0d", e.value, value);
        failures++;
      end
      if (last !== e.last) begin
        $error("last_emitted: expected %0d, actual %0d", e.last, last);
        failures++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [23:0]                     s_tdata;  // blue_in, green_in, red_in
  logic                            s_tuser;  // start_of_frame
  logic                            m_tvalid;
  logic                            m_tready;
  logic [7:0]                      m_tdata;  // edge_value
  logic                            m_tlast;  // last_emitted
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [lapedge_pkg::ADDR_W-1:0]  paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  lap_edge_predictor sb;
  int                max_gap;
  int                rx_wait;
  logic              rx_took;
  logic              sof_due;
  int                style;
  int                base;
  int                random_items;
  int                cycles;

  laplacian_edge_threshold DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output checked before input noted: a word never comes from the same edge's pixel
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        sb.check_word(m_tdata, m_tlast);
        rx_took = 1'b1;
      end
      if (s_tvalid && s_tready)
        sb.predict_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tuser);
    end
  end

  always @(negedge clk) begin
    if (rx_took) begin
      rx_took = 1'b0;
      rx_wait = $urandom_range(0, max_gap);
    end
    if (rx_wait > 0) begin
      m_tready = 1'b0;
      rx_wait--;
    end else begin
      m_tready = 1'b1;
    end
  end

  task automatic apb_access(logic [1:0] idx, logic wr, logic [31:0] data,
                            output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_register(logic [1:0] idx);
    logic [31:0] rd;
    apb_access(idx, 1'b0, 32'd0, rd);
    if (rd !== sb.register_value(idx)) begin
      $error("register %0d: expected %0d, actual %0d", idx, sb.register_value(idx), rd);
      sb.failures++;
    end
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] val);
    logic [31:0] rd;
    apb_access(idx, 1'b1, val, rd);
    sb.set_register(idx, val);
    check_register(idx);
  endtask

  // stop sending, wait for every pending word, then let the pipeline empty
  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // a wider frame restarts at row 0 so no unwritten line buffer entry is read
  task automatic configure(int w, int h, int t);
    int old_w;
    drain();
    old_w = sb.eff_width();
    write_register(lapedge_pkg::REG_FRAME_WIDTH, w);
    write_register(lapedge_pkg::REG_FRAME_HEIGHT, h);
    write_register(lapedge_pkg::REG_THRESHOLD, t);
    if (sb.eff_width() > old_w) sof_due = 1'b1;
  endtask

  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic sof);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {r, g, b};
    s_tuser  = sof | sof_due;
    sof_due  = 1'b0;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_gray(logic [7:0] v, logic sof);
    send_pixel(v, v, v, sof);
  endtask

  function automatic logic [23:0] rand_pixel();
    logic [7:0] v;
    case (style)
      0: return 24'($urandom);
      1: begin
        if ($urandom_range(0, 3) == 0) return 24'($urandom);
        return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
      end
      default: begin
        v = 8'(base + $urandom_range(0, 7));
        return {v, v, v};
      end
    endcase
  endfunction

  task automatic run_frames(int n, logic restart);
    int fsz;
    logic sof;
    logic [23:0] px;
    fsz = sb.eff_width() * sb.eff_height();
    for (int i = 0; i < n; i++) begin
      sof = 1'b0;
      if (restart && i % fsz == 0 && (i == 0 || $urandom_range(0, 1) != 0)) sof = 1'b1;
      if ($urandom_range(0, 63) == 0) sof = 1'b1;
      px = rand_pixel();
      send_pixel(px[7:0], px[15:8], px[23:16], sof);
    end
  endtask

  initial begin
    int w, h, t, n, fsz;
    logic [23:0] px;
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rx_wait  = 0;
    rx_took  = 1'b0;
    sof_due  = 1'b1;
    max_gap  = 14;
    style    = 0;
    base     = 0;
    cycles   = 0;
    random_items = 0;
    sb = new;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    check_register(lapedge_pkg::REG_FRAME_WIDTH);
    check_register(lapedge_pkg::REG_FRAME_HEIGHT);
    check_register(lapedge_pkg::REG_THRESHOLD);

    // centre white in black: Laplacian +1020, just above threshold
    configure(3, 3, 1019);
    for (int i = 0; i < 9; i++) send_gray((i == 4) ? 8'd255 : 8'd0, i == 0);
    // centre black in white: -1020, not above; frame follows without a start flag
    configure(3, 3, 1020);
    for (int i = 0; i < 9; i++) send_gray((i == 4) ? 8'd0 : 8'd255, 1'b0);
    // single colour extremes, then a restart part way into the frame, flat field
    configure(3, 3, 0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_gray(8'd100, 1'b0);
    for (int i = 0; i < 9; i++) send_gray(8'd100, i == 0);

    // widest frame (register above the clamp): one full row and the start of the next
    configure(2047, 3, $urandom_range(0, 255));
    style   = 0;
    max_gap = 4;
    for (int i = 0; i < lapedge_pkg::MAX_WIDTH + 40; i++) begin
      px = rand_pixel();
      send_pixel(px[7:0], px[15:8], px[23:16], i == 0);
    end

    while (random_items < 550) begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 2);
        1: w = $urandom_range(13, 40);
        default: w = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0: h = $urandom_range(0, 2);
        1: h = ($urandom_range(0, 1) != 0) ? 4095 : $urandom_range(9, 4095);
        default: h = $urandom_range(3, 8);
      endcase
      case ($urandom_range(0, 7))
        0: t = 0;
        1: t = 1023;
        2: t = 1020;
        default: t = $urandom_range(0, 400);
      endcase
      configure(w, h, t);
      style   = $urandom_range(0, 2);
      base    = $urandom_range(0, 248);
      max_gap = ($urandom_range(0, 4) == 0) ? 0 : 14;
      fsz = sb.eff_width() * sb.eff_height();
      n = $urandom_range(1, 3) * fsz + $urandom_range(0, fsz - 1);
      if (n > 400) n = $urandom_range(150, 400);
      run_frames(n, $urandom_range(0, 3) != 0);
      random_items += n;
    end

    max_gap = 14;
    drain();
    repeat (20) @(negedge clk);
    if (sb.failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
